>>> rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared constants, codes and state encodings for the allocator core.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int MaxOrder   = 10;
   localparam int MaxPages   = 4096;
   localparam int PageW      = 36;
   localparam int CountW     = 13;
   localparam int OrderW     = 4;
   localparam int StoreDepth = 2 * MaxPages;
   localparam int AddrW      = $clog2(StoreDepth);
   localparam int NumOrders  = MaxOrder + 1;

   typedef enum logic [1:0] {
      CMD_INIT    = 2'd0,
      CMD_ALLOC   = 2'd1,
      CMD_FREE    = 2'd2,
      CMD_RESERVE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_INIT  = 3'd1,
      ST_ORDER_BIG = 3'd2,
      ST_NO_MEM    = 3'd3,
      ST_BAD_ADDR  = 3'd4,
      ST_MISALIGN  = 3'd5,
      ST_REGION    = 3'd6,
      ST_FULL      = 3'd7
   } status_type;

   localparam logic [1:0] CsrRegionStart = 2'd0;
   localparam logic [1:0] CsrRegionEnd   = 2'd1;
   localparam logic [1:0] CsrFreeStart   = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_INIT_STEP,
      S_ALLOC_SCAN,
      S_ALLOC_RD,
      S_ALLOC_WAIT,
      S_ALLOC_SPLIT,
      S_FREE_BUDDY,
      S_FIND_RD,
      S_FIND_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FREE_PUSH,
      S_RES_ORDER,
      S_RES_NEXT,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      FIND_FREE1,
      FIND_FREE2,
      FIND_RES
   } find_type;

   function automatic logic [CountW-1:0] stack_cap(input logic [OrderW-1:0] o);
      return CountW'(MaxPages >> o);
   endfunction

   function automatic logic [AddrW-1:0] stack_base(input logic [OrderW-1:0] o);
      logic [AddrW:0] b;
      b = (AddrW+1)'(StoreDepth) - ((AddrW+1)'(StoreDepth) >> o);
      return b[AddrW-1:0];
   endfunction

   function automatic logic [PageW-1:0] blk_size(input logic [OrderW-1:0] o);
      return PageW'(1) << o;
   endfunction

endpackage

>>> rtl/bpa_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel interface
// Carries the request and response payloads of the allocator.
// ----------------------------------------------------------------------------
interface bpa_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic [bpa_pkg::PageW-1:0]     page_number;
   logic [bpa_pkg::PageW-1:0]     end_page;
   logic [bpa_pkg::OrderW-1:0]    block_order;
   modport source (output valid, command, page_number, end_page, block_order,
                   input ready);
   modport sink (input valid, command, page_number, end_page, block_order,
                 output ready);
endinterface

interface bpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    status;
   logic [bpa_pkg::PageW-1:0]     result_page;
   logic [bpa_pkg::CountW-1:0]    free_page_count;
   logic [bpa_pkg::CountW-1:0]    total_page_count;
   modport source (output valid, status, result_page, free_page_count,
                   total_page_count, input ready);
   modport sink (input valid, status, result_page, free_page_count,
                 total_page_count, output ready);
endinterface

>>> rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/buddy_page_allocator_core.sv
// ----------------------------------------------------------------------------
// Buddy page allocator core
// Requests arrive on req (init, allocate, free, reserve); one response per
// request leaves on rsp. The csr port loads region start, region end and
// free start; write it only while idle. A sequencer drives one shared
// 36-bit compare/add datapath and a single-port free block RAM that holds a
// last-in-first-out stack per order.
// Work varies with the command: allocate pops a block and splits it down
// one order per step, free walks each buddy stack (moving entries down
// when a buddy is removed), init carves one block or skips one page per
// step, reserve makes up to 11 order probes per page step, each a stack
// walk. Only one request is in flight; req.ready is low from acceptance
// until its response has been taken. The single RAM port is the limiting
// resource throughout.
// Reset clears the sequencer state, stack fill counts and the init flag; the
// RAM needs no clearing. A stalled response simply holds in its register.
// ----------------------------------------------------------------------------
module buddy_page_allocator_core (
   input  logic                              clock,
   input  logic                              reset,
   bpa_req_if.sink                           req,
   bpa_rsp_if.source                         rsp,
   input  logic                              csr_write_enable,
   input  logic [1:0]                        csr_index,
   input  logic [bpa_pkg::PageW-1:0]         csr_write_data
);
   localparam int PW = bpa_pkg::PageW;
   localparam int CW = bpa_pkg::CountW;
   localparam int OW = bpa_pkg::OrderW;
   localparam int AW = bpa_pkg::AddrW;
   localparam int NO = bpa_pkg::NumOrders;

   bpa_pkg::state_type state_ff, state_in;

   logic [PW-1:0] reg_lo_ff, reg_hi_ff, reg_fs_ff;
   logic [PW-1:0] low_ff, low_in, high_ff, high_in;
   logic [CW-1:0] fill_ff [NO];
   logic [CW-1:0] fill_in [NO];
   logic          rdy_ff, rdy_in;
   logic [CW-1:0] freep_ff, freep_in, total_ff, total_in;

   logic [1:0]    cmd_ff, cmd_in;
   logic [PW-1:0] pg_ff, pg_in, endp_ff, endp_in;
   logic [OW-1:0] ord_ff, ord_in;

   logic [PW-1:0] cur_ff, cur_in, stop_ff, stop_in;
   logic [PW-1:0] p_ff, p_in, b_ff, b_in;
   logic [OW-1:0] o_ff, o_in, c_ff, c_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] at_ff, at_in;
   bpa_pkg::find_type fmode_ff, fmode_in;
   logic          pass2_ff, pass2_in;
   logic [PW-1:0] addr_ff, addr_in;

   logic [2:0]    st_ff, st_in;
   logic [PW-1:0] rpage_ff, rpage_in;
   logic          rvalid_ff, rvalid_in;

   logic          we;
   logic [AW-1:0] ram_addr;
   logic [PW-1:0] ram_wdata, ram_rdata;

   bpa_ram #(.Width(PW), .Depth(bpa_pkg::StoreDepth)) u_store (
      .clock (clock),
      .we    (we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // shared datapath helpers
   logic [PW-1:0] sz_o;
   logic [PW:0]   cur_plus;
   logic          aligned_o;
   logic [PW-1:0] rem;
   logic [PW-1:0] fs_max;
   logic [PW:0]   tot_diff;
   logic          b_in_range;
   logic [PW-1:0] b_next;

   always_comb begin
      sz_o       = bpa_pkg::blk_size(o_ff);
      cur_plus   = {1'b0, cur_ff} + {1'b0, sz_o};
      aligned_o  = (cur_ff & (sz_o - PW'(1))) == '0;
      rem        = high_ff - cur_ff;
      fs_max     = (reg_fs_ff > reg_lo_ff) ? reg_fs_ff : reg_lo_ff;
      tot_diff   = (reg_hi_ff > reg_lo_ff) ? {1'b0, reg_hi_ff - reg_lo_ff} : '0;
      b_next     = p_ff ^ sz_o;
      b_in_range = (b_next >= low_ff) && (b_next < high_ff);
   end

   assign req.ready            = (state_ff == bpa_pkg::S_IDLE);
   assign rsp.valid            = rvalid_ff;
   assign rsp.status           = st_ff;
   assign rsp.result_page      = rpage_ff;
   assign rsp.free_page_count  = freep_ff;
   assign rsp.total_page_count = total_ff;

   // next-state and datapath control
   always_comb begin
      state_in = state_ff;
      low_in = low_ff; high_in = high_ff;
      for (int k = 0; k < NO; k++) fill_in[k] = fill_ff[k];
      rdy_in = rdy_ff; freep_in = freep_ff; total_in = total_ff;
      cmd_in = cmd_ff; pg_in = pg_ff; endp_in = endp_ff; ord_in = ord_ff;
      cur_in = cur_ff; stop_in = stop_ff; p_in = p_ff; b_in = b_ff;
      o_in = o_ff; c_in = c_ff; idx_in = idx_ff; at_in = at_ff;
      fmode_in = fmode_ff; pass2_in = pass2_ff; addr_in = addr_ff;
      st_in = st_ff; rpage_in = rpage_ff; rvalid_in = rvalid_ff;
      we = 1'b0;
      ram_addr = '0;
      ram_wdata = '0;

      case (state_ff)
         bpa_pkg::S_IDLE: begin
            if (req.valid) begin
               cmd_in = req.command; pg_in = req.page_number;
               endp_in = req.end_page; ord_in = req.block_order;
               state_in = bpa_pkg::S_DISPATCH;
            end
         end
         bpa_pkg::S_DISPATCH: begin
            rpage_in = '0;
            st_in = bpa_pkg::ST_OK;
            state_in = bpa_pkg::S_DONE;
            case (bpa_pkg::cmd_type'(cmd_ff))
               bpa_pkg::CMD_INIT: begin
                  if (tot_diff > (PW+1)'(bpa_pkg::MaxPages)) begin
                     st_in = bpa_pkg::ST_REGION;
                  end else begin
                     for (int k = 0; k < NO; k++) fill_in[k] = '0;
                     low_in = reg_lo_ff; high_in = reg_hi_ff;
                     total_in = tot_diff[CW-1:0];
                     freep_in = '0;
                     cur_in = fs_max;
                     state_in = bpa_pkg::S_INIT_STEP;
                  end
               end
               bpa_pkg::CMD_ALLOC: begin
                  if (!rdy_ff) st_in = bpa_pkg::ST_NOT_INIT;
                  else if (ord_ff > OW'(bpa_pkg::MaxOrder)) st_in = bpa_pkg::ST_ORDER_BIG;
                  else begin
                     c_in = ord_ff;
                     state_in = bpa_pkg::S_ALLOC_SCAN;
                  end
               end
               bpa_pkg::CMD_FREE: begin
                  if (!rdy_ff) st_in = bpa_pkg::ST_NOT_INIT;
                  else if (ord_ff > OW'(bpa_pkg::MaxOrder)) st_in = bpa_pkg::ST_ORDER_BIG;
                  else if (pg_ff < low_ff || pg_ff >= high_ff) st_in = bpa_pkg::ST_BAD_ADDR;
                  else if ((pg_ff & (bpa_pkg::blk_size(ord_ff) - PW'(1))) != '0)
                     st_in = bpa_pkg::ST_MISALIGN;
                  else begin
                     o_in = ord_ff; p_in = pg_ff; pass2_in = 1'b0;
                     state_in = bpa_pkg::S_FREE_BUDDY;
                  end
               end
               default: begin
                  if (!rdy_ff) st_in = bpa_pkg::ST_NOT_INIT;
                  else begin
                     cur_in  = (pg_ff > low_ff) ? pg_ff : low_ff;
                     stop_in = (endp_ff < high_ff) ? endp_ff : high_ff;
                     o_in = OW'(bpa_pkg::MaxOrder);
                     state_in = bpa_pkg::S_RES_ORDER;
                  end
               end
            endcase
         end
         // one carving step per cycle, order search is a priority pick
         bpa_pkg::S_INIT_STEP: begin
            if (cur_ff >= high_ff) begin
               rdy_in = 1'b1;
               state_in = bpa_pkg::S_DONE;
            end else begin
               logic found;
               logic [OW-1:0] fo;
               found = 1'b0; fo = '0;
               for (int k = 0; k < NO; k++) begin
                  if (rem >= bpa_pkg::blk_size(OW'(k)) &&
                      (cur_ff & (bpa_pkg::blk_size(OW'(k)) - PW'(1))) == '0) begin
                     found = 1'b1; fo = OW'(k);
                  end
               end
               if (found) begin
                  if (fill_ff[fo] < bpa_pkg::stack_cap(fo)) begin
                     we = 1'b1;
                     ram_addr = bpa_pkg::stack_base(fo) + AW'(fill_ff[fo]);
                     ram_wdata = cur_ff;
                     fill_in[fo] = fill_ff[fo] + CW'(1);
                  end
                  freep_in = freep_ff + CW'(bpa_pkg::blk_size(fo));
                  cur_in = cur_ff + bpa_pkg::blk_size(fo);
               end else begin
                  cur_in = cur_ff + PW'(1);
               end
            end
         end
         bpa_pkg::S_ALLOC_SCAN: begin
            if (fill_ff[c_ff] != '0) begin
               logic full;
               full = 1'b0;
               for (int k = 0; k < NO; k++)
                  if (OW'(k) >= ord_ff && OW'(k) < c_ff &&
                      fill_ff[k] >= bpa_pkg::stack_cap(OW'(k))) full = 1'b1;
               if (full) begin
                  st_in = bpa_pkg::ST_FULL;
                  state_in = bpa_pkg::S_DONE;
               end else begin
                  fill_in[c_ff] = fill_ff[c_ff] - CW'(1);
                  state_in = bpa_pkg::S_ALLOC_RD;
               end
            end else if (c_ff == OW'(bpa_pkg::MaxOrder)) begin
               st_in = bpa_pkg::ST_NO_MEM;
               state_in = bpa_pkg::S_DONE;
            end else begin
               c_in = c_ff + OW'(1);
            end
         end
         bpa_pkg::S_ALLOC_RD: begin
            ram_addr = bpa_pkg::stack_base(c_ff) + AW'(fill_ff[c_ff]);
            state_in = bpa_pkg::S_ALLOC_WAIT;
         end
         bpa_pkg::S_ALLOC_WAIT: begin
            addr_in = ram_rdata;
            state_in = bpa_pkg::S_ALLOC_SPLIT;
         end
         bpa_pkg::S_ALLOC_SPLIT: begin
            if (c_ff > ord_ff) begin
               logic [OW-1:0] cm;
               cm = c_ff - OW'(1);
               if (fill_ff[cm] < bpa_pkg::stack_cap(cm)) begin
                  we = 1'b1;
                  ram_addr = bpa_pkg::stack_base(cm) + AW'(fill_ff[cm]);
                  ram_wdata = addr_ff + bpa_pkg::blk_size(cm);
                  fill_in[cm] = fill_ff[cm] + CW'(1);
               end
               c_in = cm;
            end else begin
               freep_in = freep_ff - CW'(bpa_pkg::blk_size(ord_ff));
               rpage_in = addr_ff;
               state_in = bpa_pkg::S_DONE;
            end
         end
         // buddy test for current order; search stack if below the top order and in range
         bpa_pkg::S_FREE_BUDDY: begin
            if (o_ff < OW'(bpa_pkg::MaxOrder) && b_in_range) begin
               b_in = b_next;
               idx_in = fill_ff[o_ff];
               fmode_in = pass2_ff ? bpa_pkg::FIND_FREE2 : bpa_pkg::FIND_FREE1;
               state_in = bpa_pkg::S_FIND_RD;
            end else begin
               state_in = bpa_pkg::S_FREE_PUSH;
            end
         end
         bpa_pkg::S_FIND_RD: begin
            if (idx_ff == '0) begin
               // not found
               if (fmode_ff == bpa_pkg::FIND_RES) begin
                  if (o_ff == '0) begin
                     cur_in = cur_ff + PW'(1);
                     state_in = bpa_pkg::S_RES_NEXT;
                  end else begin
                     o_in = o_ff - OW'(1);
                     state_in = bpa_pkg::S_RES_ORDER;
                  end
               end else begin
                  state_in = bpa_pkg::S_FREE_PUSH;
               end
            end else begin
               idx_in = idx_ff - CW'(1);
               ram_addr = bpa_pkg::stack_base(o_ff) + AW'(idx_ff - CW'(1));
               state_in = bpa_pkg::S_FIND_CMP;
            end
         end
         bpa_pkg::S_FIND_CMP: begin
            if (ram_rdata == b_ff) begin
               at_in = idx_ff;
               if (fmode_ff == bpa_pkg::FIND_FREE1) begin
                  if (b_ff < p_ff) p_in = b_ff;
                  o_in = o_ff + OW'(1);
                  state_in = bpa_pkg::S_FREE_BUDDY;
               end else begin
                  state_in = bpa_pkg::S_SHIFT_RD;
               end
            end else begin
               state_in = bpa_pkg::S_FIND_RD;
            end
         end
         // move entries above at down one place
         bpa_pkg::S_SHIFT_RD: begin
            if (at_ff + CW'(1) >= fill_ff[o_ff]) begin
               fill_in[o_ff] = fill_ff[o_ff] - CW'(1);
               if (fmode_ff == bpa_pkg::FIND_RES) begin
                  freep_in = freep_ff - CW'(sz_o);
                  cur_in = cur_ff + sz_o;
                  state_in = bpa_pkg::S_RES_NEXT;
               end else begin
                  if (b_ff < p_ff) p_in = b_ff;
                  o_in = o_ff + OW'(1);
                  state_in = bpa_pkg::S_FREE_BUDDY;
               end
            end else begin
               ram_addr = bpa_pkg::stack_base(o_ff) + AW'(at_ff + CW'(1));
               state_in = bpa_pkg::S_SHIFT_WR;
            end
         end
         bpa_pkg::S_SHIFT_WR: begin
            we = 1'b1;
            ram_addr = bpa_pkg::stack_base(o_ff) + AW'(at_ff);
            ram_wdata = ram_rdata;
            at_in = at_ff + CW'(1);
            state_in = bpa_pkg::S_SHIFT_RD;
         end
         bpa_pkg::S_FREE_PUSH: begin
            if (!pass2_ff) begin
               if (fill_ff[o_ff] >= bpa_pkg::stack_cap(o_ff)) begin
                  st_in = bpa_pkg::ST_FULL;
                  state_in = bpa_pkg::S_DONE;
               end else begin
                  pass2_in = 1'b1;
                  o_in = ord_ff; p_in = pg_ff;
                  state_in = bpa_pkg::S_FREE_BUDDY;
               end
            end else begin
               we = 1'b1;
               ram_addr = bpa_pkg::stack_base(o_ff) + AW'(fill_ff[o_ff]);
               ram_wdata = p_ff;
               fill_in[o_ff] = fill_ff[o_ff] + CW'(1);
               freep_in = freep_ff + CW'(sz_o);
               state_in = bpa_pkg::S_DONE;
            end
         end
         bpa_pkg::S_RES_ORDER: begin
            if (cur_ff >= stop_ff) begin
               state_in = bpa_pkg::S_DONE;
            end else if (cur_plus > {1'b0, endp_ff} || !aligned_o) begin
               if (o_ff == '0) begin
                  cur_in = cur_ff + PW'(1);
                  state_in = bpa_pkg::S_RES_NEXT;
               end else begin
                  o_in = o_ff - OW'(1);
               end
            end else begin
               b_in = cur_ff;
               idx_in = fill_ff[o_ff];
               fmode_in = bpa_pkg::FIND_RES;
               state_in = bpa_pkg::S_FIND_RD;
            end
         end
         bpa_pkg::S_RES_NEXT: begin
            o_in = OW'(bpa_pkg::MaxOrder);
            state_in = bpa_pkg::S_RES_ORDER;
         end
         bpa_pkg::S_DONE: begin
            if (!rvalid_ff) begin
               rvalid_in = 1'b1;
            end else if (rsp.ready) begin
               rvalid_in = 1'b0;
               state_in = bpa_pkg::S_IDLE;
            end
         end
         default: state_in = bpa_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::S_IDLE;
         for (int k = 0; k < NO; k++) fill_ff[k] <= '0;
         rdy_ff <= 1'b0; freep_ff <= '0; total_ff <= '0;
         low_ff <= '0; high_ff <= '0;
         reg_lo_ff <= '0; reg_hi_ff <= '0; reg_fs_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         for (int k = 0; k < NO; k++) fill_ff[k] <= fill_in[k];
         rdy_ff <= rdy_in; freep_ff <= freep_in; total_ff <= total_in;
         low_ff <= low_in; high_ff <= high_in;
         rvalid_ff <= rvalid_in;
         if (csr_write_enable) begin
            case (csr_index)
               bpa_pkg::CsrRegionStart: reg_lo_ff <= csr_write_data;
               bpa_pkg::CsrRegionEnd:   reg_hi_ff <= csr_write_data;
               bpa_pkg::CsrFreeStart:   reg_fs_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; pg_ff <= pg_in; endp_ff <= endp_in; ord_ff <= ord_in;
      cur_ff <= cur_in; stop_ff <= stop_in; p_ff <= p_in; b_ff <= b_in;
      o_ff <= o_in; c_ff <= c_in; idx_ff <= idx_in; at_ff <= at_in;
      fmode_ff <= fmode_in; pass2_ff <= pass2_in; addr_ff <= addr_in;
      st_ff <= st_in; rpage_ff <= rpage_in;
   end
endmodule
